>>> hdl/pcw_pkg.sv
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared types, constants and helper functions of the chunk walker.
// ----------------------------------------------------------------------------
package pcw_pkg;

  // default offset width and field widths
  localparam int unsigned OffsetWidthDef = 32;
  localparam int unsigned LenW           = 32;
  localparam int unsigned CntW           = LenW + 1;
  localparam int unsigned OutW           = 32;

  // minimum file length and per-chunk overhead
  localparam logic [LenW-1:0] MinFileLen    = 32'd20;
  localparam logic [3:0]      ChunkOverhead = 4'd12;
  localparam logic [3:0]      FirstChunkOfs = 4'd8;

  // event codes
  typedef enum logic [2:0] {
    EV_CHUNK   = 3'd0,
    EV_END     = 3'd1,
    EV_NOTPNG  = 3'd2,
    EV_CORRUPT = 3'd3,
    EV_NOEND   = 3'd4
  } event_t;

  // chunk classes
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_SIG   = 2'd1,
    CLS_EXIF  = 2'd2,
    CLS_END   = 2'd3
  } class_t;

  // chunk type words
  localparam logic [31:0] TypeIend = 32'h49454E44;
  localparam logic [31:0] TypeText = 32'h74657874;
  localparam logic [31:0] TypeItxt = 32'h69747874;
  localparam logic [31:0] TypeSeal = 32'h7365616C;
  localparam logic [31:0] TypeExif = 32'h65786966;

  // one result word
  typedef struct packed {
    logic [2:0]      event_res;
    logic [1:0]      chunk_class;
    logic [OutW-1:0] chunk_offset;
    logic [OutW-1:0] data_start;
    logic [OutW-1:0] data_end;
  } res_t;

  // file signature byte by position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      3'd7:    v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // lower-case fold of one ascii byte
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      v = b + 8'h20;
    end
    return v;
  endfunction

  // class of a non-end chunk type, letter case ignored
  function automatic class_t classify(input logic [31:0] w);
    logic [31:0] f;
    class_t      c;
    f = {fold_byte(w[31:24]), fold_byte(w[23:16]), fold_byte(w[15:8]), fold_byte(w[7:0])};
    if (f == TypeText || f == TypeItxt || f == TypeSeal) begin
      c = CLS_SIG;
    end else if (f == TypeExif) begin
      c = CLS_EXIF;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

>>> hdl/pcw_ifs.sv
// ----------------------------------------------------------------------------
// pcw channel interfaces
// Valid/ready channels for input bytes, result words and configuration.
// ----------------------------------------------------------------------------
interface pcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface pcw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [1:0]  chunk_class;
  logic [31:0] chunk_offset;
  logic [31:0] data_start;
  logic [31:0] data_end;

  modport source (output valid, output event_res, output chunk_class,
                  output chunk_offset, output data_start, output data_end,
                  input ready);
  modport sink   (input valid, input event_res, input chunk_class,
                  input chunk_offset, input data_start, input data_end,
                  output ready);
endinterface

interface pcw_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_length;

  modport source (output valid, output total_length, input ready);
  modport sink   (input valid, input total_length, output ready);
endinterface

>>> hdl/pcw_walker.sv
// ----------------------------------------------------------------------------
// pcw_walker
// Walk state and per-byte next-state logic; flags at most one result a byte.
// ----------------------------------------------------------------------------
module pcw_walker
  import pcw_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = OffsetWidthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_fire,
  input  logic [7:0]      data_byte,
  input  logic            file_start,
  input  logic [LenW-1:0] total_length,
  output logic            res_valid,
  output res_t            res
);

  localparam int unsigned OW   = OFFSET_WIDTH;
  localparam int unsigned CmpW = ((OW > LenW) ? OW : LenW) + 2;

  typedef enum logic [2:0] {
    PH_SIG, PH_LEN, PH_TYPE, PH_SKIP, PH_DONE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [OW-1:0]   cur_ofs_r, cur_ofs_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [31:0]     type_r, type_nxt;
  logic            sig_ok_r, sig_ok_nxt;
  logic [OW-1:0]   next_ofs_r, next_ofs_nxt;
  logic [CntW-1:0] skip_lim_r, skip_lim_nxt;

  // state as seen by this byte, after an optional restart
  phase_t          ph_e;
  logic [CntW-1:0] cnt_e;
  logic [OW-1:0]   cur_e;
  logic [LenW-1:0] len_e;
  logic [31:0]     type_e;
  logic            sig_ok_e;

  logic [LenW-1:0] len_asm;
  logic [31:0]     type_asm;
  logic            sig_ok_asm;
  logic [CmpW-1:0] total_x;
  logic [CmpW-1:0] end_x;
  logic [OW-1:0]   ds_w;
  logic [OW-1:0]   de_w;

  // restart view
  always_comb begin
    if (file_start) begin
      ph_e     = PH_SIG;
      cnt_e    = '0;
      cur_e    = OW'(FirstChunkOfs);
      len_e    = '0;
      type_e   = '0;
      sig_ok_e = 1'b1;
    end else begin
      ph_e     = phase_r;
      cnt_e    = cnt_r;
      cur_e    = cur_ofs_r;
      len_e    = len_r;
      type_e   = type_r;
      sig_ok_e = sig_ok_r;
    end
  end

  // byte assembly and shared arithmetic
  assign len_asm    = {len_e[LenW-9:0], data_byte};
  assign type_asm   = {type_e[23:0], data_byte};
  assign sig_ok_asm = sig_ok_e & (data_byte == magic_byte(cnt_e[2:0]));
  assign total_x    = CmpW'(total_length);
  assign end_x      = CmpW'(cur_e) + CmpW'(ChunkOverhead) + CmpW'(len_asm);
  assign ds_w       = cur_e + OW'(FirstChunkOfs);
  assign de_w       = ds_w + OW'(len_e);

  // next state and result
  always_comb begin
    phase_nxt    = ph_e;
    cnt_nxt      = cnt_e;
    cur_ofs_nxt  = cur_e;
    len_nxt      = len_e;
    type_nxt     = type_e;
    sig_ok_nxt   = sig_ok_e;
    next_ofs_nxt = next_ofs_r;
    skip_lim_nxt = skip_lim_r;
    res_valid    = 1'b0;
    res          = '0;

    case (ph_e)
      PH_SIG: begin
        if (cnt_e == '0 && total_length < MinFileLen) begin
          phase_nxt     = PH_DONE;
          res_valid     = 1'b1;
          res.event_res = EV_NOTPNG;
        end else begin
          sig_ok_nxt = sig_ok_asm;
          if (cnt_e >= CntW'(7)) begin
            if (!sig_ok_asm) begin
              phase_nxt     = PH_DONE;
              res_valid     = 1'b1;
              res.event_res = EV_NOTPNG;
            end else begin
              // first chunk boundary
              cur_ofs_nxt = OW'(FirstChunkOfs);
              cnt_nxt     = '0;
              len_nxt     = '0;
              type_nxt    = '0;
              if (CmpW'(FirstChunkOfs) + CmpW'(ChunkOverhead) > total_x) begin
                phase_nxt        = PH_DONE;
                res_valid        = 1'b1;
                res.event_res    = EV_NOEND;
                res.chunk_offset = OutW'(FirstChunkOfs);
              end else begin
                phase_nxt = PH_LEN;
              end
            end
          end else begin
            cnt_nxt = cnt_e + CntW'(1);
          end
        end
      end
      PH_LEN: begin
        len_nxt = len_asm;
        if (cnt_e >= CntW'(3)) begin
          if (len_asm > total_length || end_x > total_x) begin
            phase_nxt        = PH_DONE;
            res_valid        = 1'b1;
            res.event_res    = EV_CORRUPT;
            res.chunk_offset = OutW'(cur_e);
          end else begin
            phase_nxt    = PH_TYPE;
            cnt_nxt      = '0;
            next_ofs_nxt = end_x[OW-1:0];
            skip_lim_nxt = CntW'(len_asm) + CntW'(3);
          end
        end else begin
          cnt_nxt = cnt_e + CntW'(1);
        end
      end
      PH_TYPE: begin
        type_nxt = type_asm;
        if (cnt_e >= CntW'(3)) begin
          res_valid        = 1'b1;
          res.chunk_offset = OutW'(cur_e);
          res.data_start   = OutW'(ds_w);
          res.data_end     = OutW'(de_w);
          if (type_asm == TypeIend) begin
            phase_nxt       = PH_DONE;
            res.event_res   = EV_END;
            res.chunk_class = CLS_END;
          end else begin
            phase_nxt       = PH_SKIP;
            cnt_nxt         = '0;
            res.event_res   = EV_CHUNK;
            res.chunk_class = classify(type_asm);
          end
        end else begin
          cnt_nxt = cnt_e + CntW'(1);
        end
      end
      PH_SKIP: begin
        if (cnt_e >= skip_lim_r) begin
          // next chunk boundary
          cur_ofs_nxt = next_ofs_r;
          cnt_nxt     = '0;
          len_nxt     = '0;
          type_nxt    = '0;
          if (CmpW'(next_ofs_r) + CmpW'(ChunkOverhead) > total_x) begin
            phase_nxt        = PH_DONE;
            res_valid        = 1'b1;
            res.event_res    = EV_NOEND;
            res.chunk_offset = OutW'(next_ofs_r);
          end else begin
            phase_nxt = PH_LEN;
          end
        end else begin
          cnt_nxt = cnt_e + CntW'(1);
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      cnt_r     <= '0;
      cur_ofs_r <= OW'(FirstChunkOfs);
      len_r     <= '0;
      type_r    <= '0;
      sig_ok_r  <= 1'b1;
    end else if (byte_fire) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      cur_ofs_r <= cur_ofs_nxt;
      len_r     <= len_nxt;
      type_r    <= type_nxt;
      sig_ok_r  <= sig_ok_nxt;
    end
  end

  // chunk end bookkeeping, always written before use
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      next_ofs_r <= next_ofs_nxt;
      skip_lim_r <= skip_lim_nxt;
    end
  end

endmodule

>>> hdl/pcw_out_stage.sv
// ----------------------------------------------------------------------------
// pcw_out_stage
// Result register with valid/ready handshake toward the result channel.
// ----------------------------------------------------------------------------
module pcw_out_stage
  import pcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_t      res,
  output logic      can_take,
  pcw_out_if.source out_ch
);

  logic valid_r, valid_nxt;
  res_t data_r;

  // room when empty or draining this cycle
  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.event_res    = data_r.event_res;
  assign out_ch.chunk_class  = data_r.chunk_class;
  assign out_ch.chunk_offset = data_r.chunk_offset;
  assign out_ch.data_start   = data_r.data_start;
  assign out_ch.data_end     = data_r.data_end;

endmodule

>>> hdl/png_chunk_walker.sv
// ----------------------------------------------------------------------------
// png_chunk_walker
// Streaming walker over the chunks of a PNG file, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  direction  word
//  in_ch    sink       data_byte, file_start
//  out_ch   source     event_res, chunk_class, chunk_offset, data_start, data_end
//  cfg_ch   sink       total_length
//
//  One byte a cycle while in_ch.ready is high; a result shows on out_ch in the
//  cycle after its byte is accepted. Walk logic is combinational and feeds one
//  result register, which takes a new word in the cycle it drains, so in_ch.ready
//  drops only when that register is full and out_ch.ready is low.
//  Synchronous reset restarts the walk at offset 0 and clears total_length.
//  cfg_ch is always ready.
// ----------------------------------------------------------------------------
module png_chunk_walker
  import pcw_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = OffsetWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  pcw_in_if.sink    in_ch,
  pcw_out_if.source out_ch,
  pcw_cfg_if.sink   cfg_ch
);

  logic [LenW-1:0] total_length_r;
  logic            byte_fire;
  logic            can_take;
  logic            res_valid;
  res_t            res;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= '0;
    end else if (cfg_ch.valid) begin
      total_length_r <= cfg_ch.total_length;
    end
  end

  // input handshake
  assign in_ch.ready = can_take;
  assign byte_fire   = in_ch.valid && can_take;

  pcw_walker #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_fire    (byte_fire),
    .data_byte    (in_ch.data_byte),
    .file_start   (in_ch.file_start),
    .total_length (total_length_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  pcw_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (byte_fire && res_valid),
    .res      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_chunk_walker testbench
// Streams PNG-like byte files into the walker, among them clean files with
// random chunk content, damaged signatures, bad length fields, truncated and
// overlong files and loose noise bytes. A scoreboard keeps its own copy of
// the walk and checks every result word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pcw_pkg::*;

  localparam int unsigned ItemTarget  = 900;
  localparam int unsigned TailBytes   = 150;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 400000;

  localparam logic [63:0] PngSignature = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TagEnd       = "IEND";
  localparam logic [31:0] TagText      = "text";
  localparam logic [31:0] TagItxt      = "itxt";
  localparam logic [31:0] TagMark      = 32'h7365616C;
  localparam logic [31:0] TagExif      = "exif";

  typedef enum logic [2:0] {
    WALK_SIG,
    WALK_LEN,
    WALK_TYPE,
    WALK_SKIP,
    WALK_DONE
  } walk_phase_t;

  // expected result words and a running copy of the chunk walk
  class chunk_walk_scoreboard;
    res_t        expected_q[$];
    walk_phase_t walk_phase;
    logic [31:0] file_length;
    logic [31:0] byte_pos;
    logic [31:0] chunk_ofs;
    logic [31:0] chunk_len;
    logic [31:0] tag_word;
    logic [63:0] phase_cnt;
    bit          magic_ok;
    int unsigned errors;
    int unsigned results_checked;
    int unsigned accepted_bytes;
    int unsigned walked_bytes;
    int unsigned event_tally [8];

    function new();
      file_length = '0;
      restart_walk();
    endfunction

    function void restart_walk();
      walk_phase = WALK_SIG;
      byte_pos   = '0;
      phase_cnt  = '0;
      chunk_ofs  = 32'd8;
      chunk_len  = '0;
      tag_word   = '0;
      magic_ok   = 1'b1;
    endfunction

    function void set_length(logic [31:0] len);
      file_length = len;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void expect_word(event_t ev, class_t cls, logic [31:0] ofs,
                              logic [31:0] ds, logic [31:0] de);
      res_t r;
      r.event_res    = ev;
      r.chunk_class  = cls;
      r.chunk_offset = ofs;
      r.data_start   = ds;
      r.data_end     = de;
      expected_q.push_back(r);
    endfunction

    // letters A..Z folded to lower case, other bytes kept
    function logic [31:0] lower_case(logic [31:0] w);
      logic [31:0] r;
      r = w;
      for (int i = 0; i < 4; i++) begin
        if (w[8*i +: 8] inside {[8'h41:8'h5A]}) r[8*i+5] = 1'b1;
      end
      return r;
    endfunction

    // step to a chunk boundary, the walk ends when no chunk fits after it
    function void reach_boundary(logic [31:0] ofs);
      chunk_ofs = ofs;
      phase_cnt = '0;
      chunk_len = '0;
      tag_word  = '0;
      if ({32'd0, chunk_ofs} + 64'd12 > {32'd0, file_length}) begin
        walk_phase = WALK_DONE;
        expect_word(EV_NOEND, CLS_OTHER, chunk_ofs, '0, '0);
      end else begin
        walk_phase = WALK_LEN;
      end
    endfunction

    // one accepted byte of the stream
    function void note_byte(logic [7:0] b, logic fs);
      logic [31:0] ds;
      logic [31:0] de;
      class_t      cls;
      accepted_bytes++;
      if (fs) restart_walk();
      if (walk_phase == WALK_DONE) return;
      walked_bytes++;
      case (walk_phase)
        WALK_SIG: begin
          if (byte_pos == 0 && file_length < 32'd20) begin
            walk_phase = WALK_DONE;
            expect_word(EV_NOTPNG, CLS_OTHER, '0, '0, '0);
          end else begin
            if (b != PngSignature[8*(7-phase_cnt[2:0]) +: 8]) magic_ok = 1'b0;
            if (phase_cnt >= 64'd7) begin
              if (!magic_ok) begin
                walk_phase = WALK_DONE;
                expect_word(EV_NOTPNG, CLS_OTHER, '0, '0, '0);
              end else begin
                reach_boundary(32'd8);
              end
            end else begin
              phase_cnt++;
            end
          end
        end
        WALK_LEN: begin
          chunk_len = {chunk_len[23:0], b};
          if (phase_cnt >= 64'd3) begin
            if (chunk_len > file_length ||
                {32'd0, chunk_ofs} + 64'd12 + {32'd0, chunk_len} > {32'd0, file_length}) begin
              walk_phase = WALK_DONE;
              expect_word(EV_CORRUPT, CLS_OTHER, chunk_ofs, '0, '0);
            end else begin
              walk_phase = WALK_TYPE;
              phase_cnt  = '0;
            end
          end else begin
            phase_cnt++;
          end
        end
        WALK_TYPE: begin
          tag_word = {tag_word[23:0], b};
          if (phase_cnt >= 64'd3) begin
            ds = chunk_ofs + 32'd8;
            de = ds + chunk_len;
            if (tag_word == TagEnd) begin
              walk_phase = WALK_DONE;
              expect_word(EV_END, CLS_END, chunk_ofs, ds, de);
            end else begin
              case (lower_case(tag_word))
                TagText, TagItxt, TagMark: cls = CLS_SIG;
                TagExif:                   cls = CLS_EXIF;
                default:                   cls = CLS_OTHER;
              endcase
              expect_word(EV_CHUNK, cls, chunk_ofs, ds, de);
              walk_phase = WALK_SKIP;
              phase_cnt  = '0;
            end
          end else begin
            phase_cnt++;
          end
        end
        WALK_SKIP: begin
          // data bytes plus the checksum
          if (phase_cnt >= {32'd0, chunk_len} + 64'd3) begin
            reach_boundary(chunk_ofs + 32'd12 + chunk_len);
          end else begin
            phase_cnt++;
          end
        end
        default: walk_phase = WALK_DONE;
      endcase
      byte_pos++;
    endfunction

    // compare one result word with the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: event_res %0d chunk_offset %0d",
               got.event_res, got.chunk_offset);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      event_tally[want.event_res]++;
      if (got.event_res !== want.event_res) begin
        $error("event_res expected %0d actual %0d", want.event_res, got.event_res);
        errors++;
      end
      if (got.chunk_class !== want.chunk_class) begin
        $error("chunk_class expected %0d actual %0d", want.chunk_class, got.chunk_class);
        errors++;
      end
      if (got.chunk_offset !== want.chunk_offset) begin
        $error("chunk_offset expected %0d actual %0d", want.chunk_offset, got.chunk_offset);
        errors++;
      end
      if (got.data_start !== want.data_start) begin
        $error("data_start expected %0d actual %0d", want.data_start, got.data_start);
        errors++;
      end
      if (got.data_end !== want.data_end) begin
        $error("data_end expected %0d actual %0d", want.data_end, got.data_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pcw_in_if  in_ch ();
  pcw_out_if out_ch ();
  pcw_cfg_if cfg_ch ();

  png_chunk_walker #(
    .OFFSET_WIDTH(32)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  chunk_walk_scoreboard walk_sb;
  logic [7:0]  file_q[$];
  res_t        observed;
  int unsigned cycle_count   = 0;
  int unsigned length_writes = 0;
  int unsigned idle_rate     = 20;
  bit          quiet_tail    = 1'b0;
  bit          hold_req      = 1'b0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // watch all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        observed.event_res    = out_ch.event_res;
        observed.chunk_class  = out_ch.chunk_class;
        observed.chunk_offset = out_ch.chunk_offset;
        observed.data_start   = out_ch.data_start;
        observed.data_end     = out_ch.data_end;
        walk_sb.check_result(observed);
      end
      if (in_ch.valid && in_ch.ready) begin
        walk_sb.note_byte(in_ch.data_byte, in_ch.file_start);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        walk_sb.set_length(cfg_ch.total_length);
        length_writes++;
      end
    end
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(1, 100) <= idle_rate) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void add_signature();
    add_word(PngSignature[63:32]);
    add_word(PngSignature[31:0]);
  endfunction

  // length field, type, random data and random checksum
  function automatic void add_chunk(logic [31:0] tag, int unsigned len, bit bogus_len);
    logic [31:0] field;
    field = len;
    if (bogus_len) field = $urandom_range(0, 1) ? $urandom() : len + $urandom_range(1, 40);
    add_word(field);
    add_word(tag);
    repeat (len + 4) file_q.push_back(8'($urandom()));
  endfunction

  // known chunk types in random letter case, or any four bytes
  function automatic logic [31:0] random_tag();
    logic [31:0] base;
    case ($urandom_range(0, 9))
      0:       base = TagText;
      1:       base = TagItxt;
      2:       base = TagMark;
      3:       base = TagExif;
      4:       base = "ihdr";
      5:       base = "idat";
      6:       base = "iend";
      7:       base = "texu";
      default: return $urandom();
    endcase
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 1)) base[8*i+5] = 1'b0;
    end
    return base;
  endfunction

  // random file into file_q, with the length to set and the bytes to send
  function automatic void build_random_file(output logic [31:0] cfg_len,
                                            output int unsigned send_len);
    int unsigned size;
    int unsigned pick;
    file_q.delete();
    add_signature();
    if ($urandom_range(0, 11) == 0) begin
      pick = $urandom_range(0, 7);
      file_q[pick] = file_q[pick] ^ 8'($urandom_range(1, 255));
    end
    repeat ($urandom_range(0, 5)) begin
      add_chunk(random_tag(),
                ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6),
                $urandom_range(0, 24) == 0);
    end
    if ($urandom_range(0, 3) != 0) add_chunk(TagEnd, 0, 1'b0);
    size = file_q.size();
    case ($urandom_range(0, 19))
      13, 14:  cfg_len = size - $urandom_range(1, 8);
      15, 16:  cfg_len = size + $urandom_range(1, 30);
      17:      cfg_len = $urandom_range(0, 19);
      18:      cfg_len = $urandom();
      19:      cfg_len = '1;
      default: cfg_len = size;
    endcase
    send_len = size;
    if ($urandom_range(0, 7) == 0) begin
      send_len = $urandom_range(1, size);
    end else if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        file_q.push_back(8'($urandom()));
        send_len++;
      end
    end
  endfunction

  // one input word, with a random gap ahead of it
  task automatic push_byte(input logic [7:0] b, input logic fs);
    if (!quiet_tail && $urandom_range(1, 100) <= idle_rate) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.file_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_file(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) push_byte(file_q[i], i == 0);
  endtask

  // new file length, written once the walker has gone quiet
  task automatic write_length(input logic [31:0] len);
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (walk_sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.total_length <= len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] cfg_len;
    int unsigned send_len;
    walk_sb = new();
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.file_start    <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.total_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stream without file start, length still zero: rejected at once
    push_byte(8'h89, 1'b0);
    push_byte(8'h50, 1'b0);

    // one byte short of the minimum file
    write_length(32'd19);
    push_byte(8'h89, 1'b1);

    // smallest file that holds one chunk, an end chunk
    write_length(32'd20);
    file_q.delete();
    add_signature();
    add_chunk(TagEnd, 0, 1'b0);
    send_file(16);

    // all-ones length field against the largest file length
    write_length('1);
    file_q.delete();
    add_signature();
    add_word('1);
    send_file(12);

    // damaged last signature byte
    file_q.delete();
    add_signature();
    file_q[7] = 8'h0B;
    send_file(8);

    // every chunk class, then the end chunk
    file_q.delete();
    add_signature();
    add_chunk("tEXt", 2, 1'b0);
    add_chunk("EXIF", 0, 1'b0);
    add_chunk("iTXt", 1, 1'b0);
    add_chunk(TagMark ^ 32'h20002000, 0, 1'b0);
    add_chunk("IDAT", 3, 1'b0);
    add_chunk("iend", 0, 1'b0);
    add_chunk(TagEnd, 0, 1'b0);
    write_length(file_q.size());
    send_file(file_q.size());

    // file runs out without an end chunk
    file_q.delete();
    add_signature();
    add_chunk("IDAT", 1, 1'b0);
    write_length(file_q.size());
    send_file(file_q.size());

    // length lowered in mid signature leaves no room for a first chunk
    file_q.delete();
    add_signature();
    write_length(32'd30);
    for (int i = 0; i < 4; i++) push_byte(file_q[i], i == 0);
    write_length(32'd19);
    for (int i = 4; i < 8; i++) push_byte(file_q[i], 1'b0);

    // receiver holds off while a file of empty chunks keeps coming
    file_q.delete();
    add_signature();
    repeat (8) add_chunk(random_tag(), 0, 1'b0);
    add_chunk(TagEnd, 0, 1'b0);
    write_length(file_q.size());
    hold_req = 1'b1;
    send_file(file_q.size());

    // random files and noise, no gaps near the end
    while (walk_sb.accepted_bytes < ItemTarget) begin
      quiet_tail = walk_sb.accepted_bytes + TailBytes >= ItemTarget;
      case ($urandom_range(0, 2))
        0:       idle_rate = 0;
        1:       idle_rate = 10;
        default: idle_rate = 30;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 10)) push_byte(8'($urandom()), $urandom_range(0, 3) == 0);
      end else begin
        build_random_file(cfg_len, send_len);
        write_length(cfg_len);
        send_file(send_len);
      end
    end

    // drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (walk_sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("accepted %0d bytes, walked %0d under %0d file length settings, %0d result words checked",
             walk_sb.accepted_bytes, walk_sb.walked_bytes, length_writes,
             walk_sb.results_checked);
    $display("chunks %0d, end chunks %0d, not png %0d, corrupted %0d, no end chunk %0d",
             walk_sb.event_tally[EV_CHUNK], walk_sb.event_tally[EV_END],
             walk_sb.event_tally[EV_NOTPNG], walk_sb.event_tally[EV_CORRUPT],
             walk_sb.event_tally[EV_NOEND]);
    if (walk_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
